[src/dfq_pkg.sv]
// ----------------------------------------------------------------------------
// dfq_pkg
// Types and codes shared by the duplicate-rejecting FIFO queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NEGATIVE  = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic {
    FN_INSERT = 1'b0,
    FN_REMOVE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP
  } state_t;

endpackage

[src/dedup_fifo_queue_unit.sv]
// ----------------------------------------------------------------------------
// dedup_fifo_queue_unit
// FIFO queue of non-negative values that rejects duplicates, held in a ring
// memory with a registered read.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result shows on
// status/result_value for one cycle with done high, in the cycle after the work
// ends; the receiver cannot stall it. A negative insert or a remove from an
// empty queue is answered straight from idle, any other remove through the pop
// state. An insert reads every queued entry through the single memory read
// port, one a cycle; a duplicate found early ends the scan at once. A new
// request may be taken in the same cycle that done is high.
module dedup_fifo_queue_unit
  import dfq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                func,
  input  logic signed [31:0]  value,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [VALUE_W-1:0]  result_value
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = IDX_W + 2;

  logic [VALUE_W-1:0] mem [CAPACITY];

  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   k, k_next;
  logic [IDX_W-1:0]   rptr, rptr_next;
  logic               rd_pending, rd_pending_next;
  logic [VALUE_W-1:0] val, val_next;
  logic [VALUE_W-1:0] rd_data;
  logic               done_next;
  status_t            status_q, status_next;
  logic [VALUE_W-1:0] result_next;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   tail;
  logic [SUM_W-1:0]   tail_sum;
  logic               match;

  assign busy   = (state != S_IDLE);
  assign status = status_q;

  // tail = (head + count) mod CAPACITY; sum stays below 2*CAPACITY
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  always_comb begin
    if (tail_sum >= SUM_W'(CAPACITY)) begin
      tail = IDX_W'(tail_sum - SUM_W'(CAPACITY));
    end else begin
      tail = IDX_W'(tail_sum);
    end
  end

  assign match = rd_pending && (rd_data == val);

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    k_next          = k;
    rptr_next       = rptr;
    rd_pending_next = 1'b0;
    val_next        = val;
    done_next       = 1'b0;
    status_next     = status_q;
    result_next     = result_value;
    rd_en           = 1'b0;
    rd_addr         = rptr;
    wr_en           = 1'b0;

    case (state)
      S_IDLE: begin
        if (start) begin
          val_next = value[VALUE_W-1:0];
          if (func_t'(func) == FN_INSERT) begin
            if (value[31]) begin
              done_next   = 1'b1;
              status_next = ST_NEGATIVE;
              result_next = '0;
            end else begin
              k_next     = '0;
              rptr_next  = head;
              state_next = S_SCAN;
            end
          end else begin
            if (count == '0) begin
              done_next   = 1'b1;
              status_next = ST_EMPTY;
              result_next = '0;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head;
              state_next = S_POP;
            end
          end
        end
      end

      S_SCAN: begin
        if (match) begin
          done_next   = 1'b1;
          status_next = ST_DUPLICATE;
          result_next = '0;
          state_next  = S_IDLE;
        end else if (k == count) begin
          // every queued entry compared, no hit
          done_next  = 1'b1;
          state_next = S_IDLE;
          if (count == CNT_W'(CAPACITY)) begin
            status_next = ST_FULL;
            result_next = '0;
          end else begin
            wr_en       = 1'b1;
            count_next  = count + 1'b1;
            status_next = ST_OK;
            result_next = val;
          end
        end else begin
          rd_en           = 1'b1;
          rd_addr         = rptr;
          rd_pending_next = 1'b1;
          k_next          = k + 1'b1;
          rptr_next       = (rptr == IDX_W'(CAPACITY - 1)) ? '0 : rptr + 1'b1;
        end
      end

      S_POP: begin
        done_next   = 1'b1;
        status_next = ST_OK;
        result_next = rd_data;
        head_next   = (head == IDX_W'(CAPACITY - 1)) ? '0 : head + 1'b1;
        count_next  = count - 1'b1;
        state_next  = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= val;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      rd_pending <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      rd_pending <= rd_pending_next;
      done       <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k            <= k_next;
    rptr         <= rptr_next;
    val          <= val_next;
    status_q     <= status_next;
    result_value <= result_next;
  end

  // results only appear once the unit is back to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("request dropped");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (result_value == '0))
    else $error("error result carries a value");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (k <= count))
    else $error("scan ran past the live entries");

endmodule

[test/tb_dedup_fifo_queue_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dedup_fifo_queue_unit
// Self-checking bench for the duplicate-rejecting FIFO queue: a short table
// of directed requests, then random insert/remove traffic with fill and drain
// bursts, each checked against an in-bench queue model or a pinned answer.
// ----------------------------------------------------------------------------
module tb_dedup_fifo_queue_unit;
  import dfq_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 370;

  typedef struct {
    status_t            st;
    logic [VALUE_W-1:0] rv;
  } answer_t;

  typedef struct {
    func_t              fn;
    logic [31:0]        val;
    bit                 pinned;
    status_t            st;
    logic [VALUE_W-1:0] rv;
  } row_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic                func;
  logic signed [31:0]  value;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  result_value;

  // queue model
  logic [VALUE_W-1:0] model_store [QUEUE_DEPTH];
  int                 model_head;
  int                 model_count;

  answer_t pending_answers [$];
  row_t    directed [$];
  answer_t got_answer;
  answer_t want_answer;
  answer_t model_answer;

  // request in flight, as seen by the monitor
  bit                 row_pinned;
  status_t            row_st;
  logic [VALUE_W-1:0] row_rv;

  int err_count;
  int cycle_count;
  int sender_idle_pct;

  dedup_fifo_queue_unit #(
    .CAPACITY(QUEUE_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .value(value),
    .done(done),
    .status(status),
    .result_value(result_value)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic answer_t queue_model_step(input func_t fn, input logic [31:0] raw);
    answer_t            ans;
    logic [VALUE_W-1:0] v;
    bit                 found;
    ans.st = ST_OK;
    ans.rv = '0;
    v = raw[VALUE_W-1:0];
    found = 1'b0;
    if (fn == FN_INSERT) begin
      for (int k = 0; k < model_count; k++) begin
        if (model_store[(model_head + k) % QUEUE_DEPTH] == v) found = 1'b1;
      end
      // check order: negative, then duplicate, then full
      if (raw[31]) begin
        ans.st = ST_NEGATIVE;
      end else if (found) begin
        ans.st = ST_DUPLICATE;
      end else if (model_count >= QUEUE_DEPTH) begin
        ans.st = ST_FULL;
      end else begin
        model_store[(model_head + model_count) % QUEUE_DEPTH] = v;
        model_count++;
        ans.rv = v;
      end
    end else begin
      if (model_count == 0) begin
        ans.st = ST_EMPTY;
      end else begin
        ans.rv = model_store[model_head];
        model_head = (model_head + 1) % QUEUE_DEPTH;
        model_count--;
      end
    end
    return ans;
  endfunction

  // result check first, then capture of a new request: a result never
  // belongs to the request taken on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        got_answer.st = status_t'(status);
        got_answer.rv = result_value;
        if (pending_answers.size() == 0) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("unexpected result: status %0d value %0h", status, result_value);
        end else begin
          want_answer = pending_answers.pop_front();
          if (got_answer.st !== want_answer.st || got_answer.rv !== want_answer.rv) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
              $display("mismatch: expected status %0d value %0h, got status %0d value %0h",
                       want_answer.st, want_answer.rv, status, result_value);
          end
        end
      end
      if (start && !busy) begin
        model_answer = queue_model_step(func_t'(func), value);
        if (row_pinned) begin
          model_answer.st = row_st;
          model_answer.rv = row_rv;
        end
        pending_answers.push_back(model_answer);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dedup_fifo_queue_unit regression: fail");
      $finish;
    end
  end

  task automatic add_row(input func_t fn, input logic [31:0] val, input bit pinned,
                         input status_t st, input logic [VALUE_W-1:0] rv);
    row_t r;
    r.fn = fn;
    r.val = val;
    r.pinned = pinned;
    r.st = st;
    r.rv = rv;
    directed.push_back(r);
  endtask

  // returns at the edge that takes the request
  task automatic issue(input func_t fn, input logic [31:0] val, input bit pinned,
                       input status_t st, input logic [VALUE_W-1:0] rv);
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    start = 1'b1;
    func = fn;
    value = val;
    row_pinned = pinned;
    row_st = st;
    row_rv = rv;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain_wait();
    @(negedge clk);
    start = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    // small pool so duplicates show up often
    if (r < 55) return $urandom_range(31);
    if (r < 80) return $urandom() & 32'h7FFF_FFFF;
    if (r < 92) return $urandom() | 32'h8000_0000;
    case ($urandom_range(3))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    int insert_pct;
    start = 1'b0;
    func = FN_INSERT;
    value = '0;
    rst = 1'b1;
    row_pinned = 1'b0;
    row_st = ST_OK;
    row_rv = '0;
    err_count = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    model_head = 0;
    model_count = 0;
    for (int k = 0; k < QUEUE_DEPTH; k++) model_store[k] = '0;

    add_row(FN_REMOVE, 32'h0000_0000, 1'b1, ST_EMPTY,     '0);
    add_row(FN_INSERT, 32'h0000_0000, 1'b1, ST_OK,        '0);
    add_row(FN_INSERT, 32'h0000_0000, 1'b1, ST_DUPLICATE, '0);
    add_row(FN_INSERT, 32'h7FFF_FFFF, 1'b1, ST_OK,        31'h7FFF_FFFF);
    add_row(FN_INSERT, 32'h8000_0000, 1'b1, ST_NEGATIVE,  '0);
    add_row(FN_INSERT, 32'hFFFF_FFFF, 1'b1, ST_NEGATIVE,  '0);
    for (int k = 1; k <= QUEUE_DEPTH - 2; k++)
      add_row(FN_INSERT, 32'(k * 32'h0111_1111), 1'b0, ST_OK, '0);
    add_row(FN_INSERT, 32'h5555_5555, 1'b1, ST_FULL,      '0);
    // both queued and full: duplicate wins
    add_row(FN_INSERT, 32'h7FFF_FFFF, 1'b1, ST_DUPLICATE, '0);
    add_row(FN_REMOVE, 32'hFFFF_FFFF, 1'b1, ST_OK,        '0);
    add_row(FN_REMOVE, 32'h0000_0000, 1'b1, ST_OK,        31'h7FFF_FFFF);
    add_row(FN_REMOVE, 32'hAAAA_AAAA, 1'b0, ST_OK,        '0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i])
      issue(directed[i].fn, directed[i].val, directed[i].pinned, directed[i].st, directed[i].rv);
    drain_wait();

    for (int p = 0; p < 3; p++) begin
      sender_idle_pct = (p == 0) ? 38 : (p == 1) ? 83 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // alternate fill and drain bursts to hit full and empty
        insert_pct = ((n / 24) % 2 == 0) ? 75 : 30;
        if ($urandom_range(99) < insert_pct)
          issue(FN_INSERT, pick_value(), 1'b0, ST_OK, '0);
        else
          issue(FN_REMOVE, $urandom(), 1'b0, ST_OK, '0);
      end
      if (p == 0) drain_wait();
    end

    drain_wait();
    repeat (QUEUE_DEPTH + 4) @(negedge clk);
    if (err_count == 0 && pending_answers.size() == 0) begin
      $display("dedup_fifo_queue_unit regression: pass");
    end else begin
      $display("dedup_fifo_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
